// ===== rtl/core/rcpg_pkg.sv =====
// Shared types, constants and the color wheel function of the rainbow cycle pixel generator.
`default_nettype none

package rcpg_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned IVL_W    = 8;
	localparam int unsigned CNT_W    = 7;
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned COLOR_W  = 8;
	localparam int unsigned PHASE_W  = 11;
	localparam int unsigned POS_W    = 8;
	localparam int unsigned QSTEP_W  = POS_W + 1;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_PIXELS  = 1'b1;

	localparam logic [IVL_W-1:0]   INTERVAL_RESET = 8'd20;
	localparam logic [CNT_W-1:0]   NUM_PIX_RESET  = 7'd64;
	localparam logic [PHASE_W-1:0] PHASE_LAST     = 11'd1279;
	localparam logic [QSTEP_W-1:0] WHEEL_SIZE     = 9'd256;

	typedef struct packed {
		logic [POS_W-1:0]   phase;
		logic [CNT_W-1:0]   n;
		logic [QSTEP_W-1:0] qstep;
		logic [CNT_W-1:0]   rstep;
	} cmd_t;

	typedef struct packed {
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
	} rgb_t;

	function automatic rgb_t wheel(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] w;
		logic [POS_W-1:0] v;
		logic [9:0]       v3;
		rgb_t             c;
		w = ~pos;
		if (w < 8'd85) begin
			v = w;
		end else if (w < 8'd170) begin
			v = w - 8'd85;
		end else begin
			v = w - 8'd170;
		end
		v3 = {2'b00, v} + {1'b0, v, 1'b0};
		if (w < 8'd85) begin
			c.r = 8'd255 - v3[7:0];
			c.g = '0;
			c.b = v3[7:0];
		end else if (w < 8'd170) begin
			c.r = '0;
			c.g = v3[7:0];
			c.b = 8'd255 - v3[7:0];
		end else begin
			c.r = v3[7:0];
			c.g = 8'd255 - v3[7:0];
			c.b = '0;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rcpg_front.sv =====
// Poll intake: configuration registers, interval check, phase counter and step divider.
`default_nettype none

module rcpg_front #(
	parameter int unsigned MAX_PIXELS = 64
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire [rcpg_pkg::TIME_W-1:0]     now_ms,
	input  wire                            push,
	output logic                           full,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [rcpg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [rcpg_pkg::CFG_DATA_W-1:0] cfg_data,
	output rcpg_pkg::cmd_t                 cmd,
	output logic                           cmd_push,
	input  wire                            cmd_full
);
	import rcpg_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t       state_q;
	logic [IVL_W-1:0]   interval_q;
	logic [CNT_W-1:0]   num_pixels_q;
	logic [TIME_W-1:0]  last_time_q;
	logic [PHASE_W-1:0] phase_q;
	logic [POS_W-1:0]   cmd_phase_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W:0]     rem_q;
	logic [QSTEP_W-1:0] quo_q;
	logic [QSTEP_W-1:0] dvd_q;
	logic [3:0]         iter_q;

	logic               accept;
	logic               do_step;
	logic [TIME_W-1:0]  elapsed;
	logic [CNT_W-1:0]   n_eff;
	logic [CNT_W:0]     rem_trial;
	logic               rem_ge;

	assign full      = (state_q != F_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = push && !full;
	assign elapsed   = now_ms - last_time_q;
	assign do_step   = accept && (elapsed >= {{(TIME_W-IVL_W){1'b0}}, interval_q});
	assign n_eff     = ({1'b0, num_pixels_q} > 8'(MAX_PIXELS)) ? 7'(MAX_PIXELS) : num_pixels_q;
	assign rem_trial = {rem_q[CNT_W-1:0], dvd_q[QSTEP_W-1]};
	assign rem_ge    = (rem_trial >= {1'b0, n_q});
	assign cmd_push  = (state_q == F_PUSH) && !cmd_full;

	always_comb begin
		cmd.phase = cmd_phase_q;
		cmd.n     = n_q;
		cmd.qstep = quo_q;
		cmd.rstep = rem_q[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q   <= INTERVAL_RESET;
			num_pixels_q <= NUM_PIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_INTERVAL_MS: interval_q   <= cfg_data;
				CFG_NUM_PIXELS:  num_pixels_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			last_time_q <= '0;
			phase_q     <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (do_step) begin
						last_time_q <= now_ms;
						phase_q     <= (phase_q >= PHASE_LAST) ? '0 : phase_q + 1'b1;
						if (n_eff != '0) begin
							state_q <= F_DIV;
						end
					end
				end
				F_DIV: begin
					if (iter_q == '0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!cmd_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE) begin
			cmd_phase_q <= phase_q[POS_W-1:0];
			n_q         <= n_eff;
			rem_q       <= '0;
			quo_q       <= '0;
			dvd_q       <= WHEEL_SIZE;
			iter_q      <= 4'(QSTEP_W - 1);
		end else if (state_q == F_DIV) begin
			rem_q  <= rem_ge ? rem_trial - {1'b0, n_q} : rem_trial;
			quo_q  <= {quo_q[QSTEP_W-2:0], rem_ge};
			dvd_q  <= {dvd_q[QSTEP_W-2:0], 1'b0};
			iter_q <= iter_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rcpg_cmd_fifo.sv =====
// Two-entry queue of step commands between the intake and the pixel sequencer.
`default_nettype none

module rcpg_cmd_fifo (
	input  wire            clk,
	input  wire            arst_n,
	input  rcpg_pkg::cmd_t wr_data,
	input  wire            wr_en,
	output logic           wr_full,
	output rcpg_pkg::cmd_t rd_data,
	input  wire            rd_en,
	output logic           rd_empty
);
	import rcpg_pkg::*;

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_full  = (count_q == (PTR_W + 1)'(DEPTH));
	assign rd_empty = (count_q == '0);
	assign do_wr    = wr_en && !wr_full;
	assign do_rd    = rd_en && !rd_empty;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rcpg_back.sv =====
// Pixel sequencer: walks the pixels of one step and holds the output register.
`default_nettype none

module rcpg_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  rcpg_pkg::cmd_t               cmd,
	input  wire                          cmd_empty,
	output logic                         cmd_pop,
	input  wire                          pop,
	output logic                         empty,
	output logic [rcpg_pkg::IDX_W-1:0]   pixel_index,
	output logic [rcpg_pkg::COLOR_W-1:0] red,
	output logic [rcpg_pkg::COLOR_W-1:0] green,
	output logic [rcpg_pkg::COLOR_W-1:0] blue,
	output logic                         frame_last
);
	import rcpg_pkg::*;

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_RUN  = 2'b10
	} back_state_t;

	back_state_t      state_q;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] pix_q;
	logic [POS_W-1:0] quo_acc_q;
	logic [CNT_W-1:0] rem_acc_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	rgb_t             out_rgb_q;
	logic             out_last_q;

	logic             advance;
	logic             is_last;
	logic [CNT_W:0]   rem_sum;
	logic             rem_wrap;
	logic [POS_W-1:0] pos;

	assign cmd_pop  = (state_q == B_IDLE) && !cmd_empty;
	assign advance  = (state_q == B_RUN) && (!out_valid_q || pop);
	assign is_last  = (pix_q == cmd_q.n - 1'b1);
	assign rem_sum  = {1'b0, rem_acc_q} + {1'b0, cmd_q.rstep};
	assign rem_wrap = (rem_sum >= {1'b0, cmd_q.n});
	assign pos      = quo_acc_q + cmd_q.phase;

	assign empty       = !out_valid_q;
	assign pixel_index = out_idx_q;
	assign red         = out_rgb_q.r;
	assign green       = out_rgb_q.g;
	assign blue        = out_rgb_q.b;
	assign frame_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (cmd_pop) begin
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					if (advance && is_last) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q     <= cmd;
			pix_q     <= '0;
			quo_acc_q <= '0;
			rem_acc_q <= '0;
		end else if (advance) begin
			pix_q     <= pix_q + 1'b1;
			quo_acc_q <= quo_acc_q + cmd_q.qstep[POS_W-1:0] + {{(POS_W-1){1'b0}}, rem_wrap};
			rem_acc_q <= rem_wrap ? CNT_W'(rem_sum - {1'b0, cmd_q.n}) : rem_sum[CNT_W-1:0];
		end
		if (advance) begin
			out_idx_q  <= pix_q[IDX_W-1:0];
			out_rgb_q  <= wheel(pos);
			out_last_q <= is_last;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rainbow_cycle_pixel_generator.sv =====
// Top level of the rainbow cycle pixel generator.
//
// Polls enter through push/full, each carrying the current millisecond time in now_ms.
// A poll at least interval_ms after the last step starts a step; other polls are taken
// one per cycle while full is low and give nothing. A step emits one beat per pixel on
// the result side, read through empty/pop, the frame's last pixel marked by frame_last.
// The intake is busy for each stepping poll: a divide of 256 by the pixel count, then
// handing the step to a two-entry command queue, held while the queue is full.
// The pixel sequencer gives one beat per cycle while the receiver keeps popping, and
// passes through an idle state between steps to take the next one from the queue.
// When the receiver stops popping, the output register holds, the sequencer stops,
// the command queue fills and full rises; no beat is lost.
// Reset sets interval_ms to 20, num_pixels to 64, the step time and phase to zero.
// The cfg channel is always ready; write it only while no step is pending.
`default_nettype none

module rainbow_cycle_pixel_generator #(
	parameter int unsigned MAX_PIXELS = 64
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire [rcpg_pkg::TIME_W-1:0]     now_ms,
	input  wire                            push,
	output logic                           full,
	output logic [rcpg_pkg::IDX_W-1:0]     pixel_index,
	output logic [rcpg_pkg::COLOR_W-1:0]   red,
	output logic [rcpg_pkg::COLOR_W-1:0]   green,
	output logic [rcpg_pkg::COLOR_W-1:0]   blue,
	output logic                           frame_last,
	output logic                           empty,
	input  wire                            pop,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [rcpg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [rcpg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rcpg_pkg::*;

	cmd_t cmd_wr;
	cmd_t cmd_rd;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;

	rcpg_front #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.now_ms    (now_ms),
		.push      (push),
		.full      (full),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_wr),
		.cmd_push  (cmd_push),
		.cmd_full  (cmd_full)
	);

	rcpg_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (cmd_wr),
		.wr_en    (cmd_push),
		.wr_full  (cmd_full),
		.rd_data  (cmd_rd),
		.rd_en    (cmd_pop),
		.rd_empty (cmd_empty)
	);

	rcpg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_rd),
		.cmd_empty   (cmd_empty),
		.cmd_pop     (cmd_pop),
		.pop         (pop),
		.empty       (empty),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_last  (frame_last)
	);

endmodule

`default_nettype wire
